>>> hdl/pmpe_pkg.sv
// ----------------------------------------------------------------------------
// pmpe_pkg
// Shared types and character codes for the plus/minus/paren evaluator.
// ----------------------------------------------------------------------------
package pmpe_pkg;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  localparam int unsigned SUM_W   = 32;
  localparam int unsigned ENTRY_W = SUM_W + 1;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DIGIT,
    OP_PLUS,
    OP_MINUS,
    OP_OPEN,
    OP_CLOSE
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_OVERFLOW,
    ST_UNMATCHED,
    ST_UNCLOSED
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  digit;
    logic        last;
    logic        push_ok;
    logic        pop_ok;
    logic        fwd;
    status_t     status;
  } item_t;

endpackage

>>> hdl/plus_minus_paren_evaluator.sv
// ----------------------------------------------------------------------------
// plus_minus_paren_evaluator
// Streaming +/- expression evaluator with parentheses and a nesting stack.
// ----------------------------------------------------------------------------
//  channel | ports                         | direction
//  input   | in_valid in_stall in_ch in_last   | one character per transaction
//  result  | out_valid out_stall out_value out_status | one per final character
//
//  One character per cycle while in_stall is low; the final character passes
//  the front stage register and then the result register. The front stage
//  tracks nesting and reads the stack (registered memory read); the next
//  stage updates the sum, with a bypass for a close right after an open.
//  Reset (rst_n low, synchronous) clears all control state; stack contents
//  need no clearing. in_stall follows out_stall only while a result is held.
// ----------------------------------------------------------------------------
module plus_minus_paren_evaluator
  import pmpe_pkg::*;
#(
  parameter int unsigned NEST_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic [1:0]  out_status
);

  localparam int unsigned LW = $clog2(NEST_DEPTH + 1);
  localparam int unsigned AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  logic               adv;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
  logic               s1_valid;
  item_t              s1_item;
  logic [AW-1:0]      s1_addr;

  assign in_stall = !adv;

  pmpe_front #(
    .NEST_DEPTH(NEST_DEPTH),
    .LW        (LW),
    .AW        (AW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ch    (in_ch),
    .in_last  (in_last),
    .adv      (adv),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_addr  (s1_addr)
  );

  pmpe_stack_mem #(
    .DEPTH (NEST_DEPTH),
    .AW    (AW),
    .DATA_W(ENTRY_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  pmpe_exec #(
    .AW(AW)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .s1_addr   (s1_addr),
    .rd_data   (mem_rdata),
    .out_stall (out_stall),
    .adv       (adv),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .out_valid (out_valid),
    .out_value (out_value),
    .out_status(out_status)
  );

endmodule

>>> hdl/pmpe_stack_mem.sv
// ----------------------------------------------------------------------------
// pmpe_stack_mem
// Nesting stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pmpe_stack_mem #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned AW     = 5,
  parameter int unsigned DATA_W = 33
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/pmpe_front.sv
// ----------------------------------------------------------------------------
// pmpe_front
// Character decode, nesting level and sticky status tracking, stack read issue.
// ----------------------------------------------------------------------------
module pmpe_front
  import pmpe_pkg::*;
#(
  parameter int unsigned NEST_DEPTH = 32,
  parameter int unsigned LW         = 6,
  parameter int unsigned AW         = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_ch,
  input  logic          in_last,
  input  logic          adv,
  input  logic          mem_we,
  input  logic [AW-1:0] mem_waddr,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr,
  output logic          s1_valid,
  output item_t         s1_item,
  output logic [AW-1:0] s1_addr
);

  logic          accept;
  logic [LW-1:0] level_r, level_nxt;
  status_t       err_r, err_nxt;
  logic          s1_valid_r, s1_valid_nxt;
  item_t         s1_item_r, item_nxt;
  logic [AW-1:0] s1_addr_r, addr_nxt;
  op_t           op;
  logic          push_ok, pop_ok;
  logic [LW-1:0] level_dec, level_upd;
  status_t       err_upd;

  assign accept    = in_valid & adv;
  assign level_dec = level_r - LW'(1);

  always_comb begin
    if (in_ch inside {[CH_0:CH_9]}) begin
      op = OP_DIGIT;
    end else begin
      case (in_ch)
        CH_PLUS:  op = OP_PLUS;
        CH_MINUS: op = OP_MINUS;
        CH_OPEN:  op = OP_OPEN;
        CH_CLOSE: op = OP_CLOSE;
        default:  op = OP_NONE;
      endcase
    end
  end

  assign push_ok = (op == OP_OPEN) && (level_r != LW'(NEST_DEPTH));
  assign pop_ok  = (op == OP_CLOSE) && (level_r != '0);

  always_comb begin
    level_upd = level_r;
    if (push_ok) begin
      level_upd = level_r + LW'(1);
    end else if (pop_ok) begin
      level_upd = level_dec;
    end
    err_upd = err_r;
    if (err_upd == ST_OK && op == OP_OPEN && !push_ok) begin
      err_upd = ST_OVERFLOW;
    end
    if (err_upd == ST_OK && op == OP_CLOSE && !pop_ok) begin
      err_upd = ST_UNMATCHED;
    end
    if (err_upd == ST_OK && in_last && level_upd != '0) begin
      err_upd = ST_UNCLOSED;
    end
  end

  assign mem_re    = accept & pop_ok;
  assign mem_raddr = level_dec[AW-1:0];

  always_comb begin
    item_nxt.op      = op;
    item_nxt.digit   = 4'(in_ch - CH_0);
    item_nxt.last    = in_last;
    item_nxt.push_ok = push_ok;
    item_nxt.pop_ok  = pop_ok;
    item_nxt.fwd     = pop_ok && mem_we && (mem_waddr == mem_raddr);
    item_nxt.status  = err_upd;
    addr_nxt         = level_r[AW-1:0];
  end

  always_comb begin
    level_nxt    = level_r;
    err_nxt      = err_r;
    s1_valid_nxt = s1_valid_r;
    if (adv) begin
      s1_valid_nxt = accept;
    end
    if (accept) begin
      level_nxt = in_last ? '0 : level_upd;
      err_nxt   = in_last ? ST_OK : err_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= '0;
      err_r      <= ST_OK;
      s1_valid_r <= 1'b0;
    end else begin
      level_r    <= level_nxt;
      err_r      <= err_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= item_nxt;
      s1_addr_r <= addr_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;
  assign s1_addr  = s1_addr_r;

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(NEST_DEPTH))
    else $error("nesting level above stack depth");

  a_level_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |=> level_r == '0 && err_r == ST_OK)
    else $error("level or status not cleared after final character");

  a_fwd_pop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_item_r.fwd |-> s1_item_r.pop_ok)
    else $error("forward flag on a transaction that does not pop");
`endif

endmodule

>>> hdl/pmpe_exec.sv
// ----------------------------------------------------------------------------
// pmpe_exec
// Running sum, pending number and sign update; stack push data; result register.
// ----------------------------------------------------------------------------
module pmpe_exec
  import pmpe_pkg::*;
#(
  parameter int unsigned AW = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s1_valid,
  input  item_t              s1_item,
  input  logic [AW-1:0]      s1_addr,
  input  logic [ENTRY_W-1:0] rd_data,
  input  logic               out_stall,
  output logic               adv,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [ENTRY_W-1:0] mem_wdata,
  output logic               out_valid,
  output logic [SUM_W-1:0]   out_value,
  output logic [1:0]         out_status
);

  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SUM_W-1:0]   pend_r, pend_nxt;
  logic               sign_r, sign_nxt;
  logic [ENTRY_W-1:0] last_w_r;
  logic               out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]   out_value_r;
  status_t            out_status_r;
  logic [ENTRY_W-1:0] top;
  logic [SUM_W-1:0]   fold, sum_new, pend_new, result;
  logic               sign_new;
  logic               fire;

  assign adv  = !out_valid_r || !out_stall;
  assign fire = adv && s1_valid;
  assign top  = s1_item.fwd ? last_w_r : rd_data;
  assign fold = sign_r ? (sum_r - pend_r) : (sum_r + pend_r);

  assign mem_we    = fire && s1_item.push_ok;
  assign mem_waddr = s1_addr;
  assign mem_wdata = {sign_r, sum_r};

  always_comb begin
    sum_new  = sum_r;
    pend_new = pend_r;
    sign_new = sign_r;
    case (s1_item.op)
      OP_DIGIT: begin
        pend_new = (pend_r << 3) + (pend_r << 1) + SUM_W'(s1_item.digit);
      end
      OP_PLUS, OP_MINUS: begin
        sum_new  = fold;
        pend_new = '0;
        sign_new = (s1_item.op == OP_MINUS);
      end
      OP_OPEN: begin
        sum_new  = '0;
        pend_new = '0;
        sign_new = 1'b0;
      end
      OP_CLOSE: begin
        pend_new = '0;
        if (s1_item.pop_ok) begin
          sum_new = top[SUM_W] ? (top[SUM_W-1:0] - fold) : (top[SUM_W-1:0] + fold);
        end else begin
          sum_new = fold;
        end
      end
      default: begin
        sum_new = sum_r;
      end
    endcase
    result = sign_new ? (sum_new - pend_new) : (sum_new + pend_new);
  end

  always_comb begin
    sum_nxt       = sum_r;
    pend_nxt      = pend_r;
    sign_nxt      = sign_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = fire && s1_item.last;
    end
    if (fire) begin
      if (s1_item.last) begin
        sum_nxt  = '0;
        pend_nxt = '0;
        sign_nxt = 1'b0;
      end else begin
        sum_nxt  = sum_new;
        pend_nxt = pend_new;
        sign_nxt = sign_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      pend_r      <= '0;
      sign_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      pend_r      <= pend_nxt;
      sign_r      <= sign_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      last_w_r <= mem_wdata;
    end
    if (fire && s1_item.last) begin
      out_value_r  <= result;
      out_status_r <= s1_item.status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_item.last |=> out_valid_r)
    else $error("final transaction produced no result");

  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_item.last |=> sum_r == '0 && pend_r == '0 && !sign_r)
    else $error("accumulators not cleared after result");

  a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> s1_item.op == OP_OPEN && adv)
    else $error("stack write outside an advancing open");
`endif

endmodule

>>> sim/plus_minus_paren_evaluator_test.sv
// ----------------------------------------------------------------------------
// plus_minus_paren_evaluator_test
// Streams character expressions into the evaluator and checks every sum and
// status it returns. A short table of hand-picked expressions runs first.
// Random expressions follow: mostly balanced, some broken, a few nested past
// the stack depth. A behavioral evaluator in the bench predicts each result
// that the table does not give, and both channels pause in random bursts.
// ----------------------------------------------------------------------------
module plus_minus_paren_evaluator_test
  import pmpe_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NEST = 32;
  localparam int PLAN_LEN = 25;

  typedef struct packed {
    logic [31:0] value;
    status_t     status;
  } total_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        last;
    bit          typed;
    logic [31:0] value;
    status_t     status;
  } row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_ch = 8'h00;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_value;
  logic [1:0]  out_status;

  logic [31:0] grp_sum = '0;
  logic [31:0] grp_num = '0;
  logic        grp_neg = 1'b0;
  logic [31:0] saved_sum [NEST];
  logic        saved_neg [NEST];
  int          depth = 0;
  status_t     run_status = ST_OK;

  total_t      totals_due [$];
  int          mismatches = 0;
  int          chars_sent = 0;
  int          exprs_done = 0;
  bit          feed_gaps = 1'b0;
  bit          sink_gaps = 1'b0;
  int          stall_left = 0;

  row_t plan [PLAN_LEN] = '{
    '{CH_0 + 8'd7, 1'b1, 1'b1, 32'd7, ST_OK},
    '{CH_CLOSE,    1'b1, 1'b1, 32'd0, ST_UNMATCHED},
    '{CH_OPEN,     1'b1, 1'b1, 32'd0, ST_UNCLOSED},
    '{8'h00,       1'b0, 1'b0, 32'd0, ST_OK},
    '{8'hFF,       1'b1, 1'b1, 32'd0, ST_OK},
    '{CH_0 + 8'd1, 1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_MINUS,    1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_OPEN,     1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_0 + 8'd2, 1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_PLUS,     1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_0 + 8'd3, 1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_CLOSE,    1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_MINUS,    1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_9,        1'b1, 1'b0, 32'd0, ST_OK},
    '{CH_MINUS,    1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_0 + 8'd5, 1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_CLOSE,    1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_OPEN,     1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_0 + 8'd4, 1'b1, 1'b0, 32'd0, ST_OK},
    '{CH_OPEN,     1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_0 + 8'd8, 1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_PLUS,     1'b1, 1'b0, 32'd0, ST_OK},
    '{CH_OPEN,     1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_CLOSE,    1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_0 + 8'd6, 1'b1, 1'b0, 32'd0, ST_OK}
  };

  plus_minus_paren_evaluator #(
    .NEST_DEPTH(NEST)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_ch      (in_ch),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_status (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void fold_number();
    grp_sum = grp_neg ? grp_sum - grp_num : grp_sum + grp_num;
    grp_num = '0;
  endfunction

  function automatic void note_status(input status_t s);
    if (run_status == ST_OK) begin
      run_status = s;
    end
  endfunction

  function automatic void eval_char(input logic [7:0] c, input logic l,
                                    output bit done, output total_t t);
    done = 1'b0;
    t = '0;
    if (c >= CH_0 && c <= CH_9) begin
      grp_num = grp_num * 32'd10 + 32'(c - CH_0);
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      fold_number();
      grp_neg = (c == CH_MINUS);
    end else if (c == CH_OPEN) begin
      if (depth < NEST) begin
        saved_sum[depth] = grp_sum;
        saved_neg[depth] = grp_neg;
        depth++;
      end else begin
        note_status(ST_OVERFLOW);
      end
      grp_sum = '0;
      grp_num = '0;
      grp_neg = 1'b0;
    end else if (c == CH_CLOSE) begin
      fold_number();
      if (depth > 0) begin
        depth--;
        grp_sum = saved_neg[depth] ? saved_sum[depth] - grp_sum
                                   : saved_sum[depth] + grp_sum;
      end else begin
        note_status(ST_UNMATCHED);
      end
    end
    if (l) begin
      fold_number();
      if (depth > 0) begin
        note_status(ST_UNCLOSED);
      end
      t.value = grp_sum;
      t.status = run_status;
      done = 1'b1;
      grp_sum = '0;
      grp_neg = 1'b0;
      depth = 0;
      run_status = ST_OK;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what,
             $signed(got), $signed(want));
    mismatches++;
  endtask

  task automatic send_char(input logic [7:0] c, input logic l, input bit typed,
                           input total_t want);
    bit     done;
    total_t t;
    if (feed_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= c;
    in_last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    eval_char(c, l, done, t);
    if (done) begin
      totals_due.push_back(typed ? want : t);
      exprs_done++;
    end
    chars_sent++;
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_0 + 8'($urandom_range(0, 9));
  endfunction

  task automatic build_expr(ref logic [7:0] text [$]);
    int kind;
    int opens;
    int n;
    int r;
    text.delete();
    opens = 0;
    kind = $urandom_range(0, 15);
    if (kind == 0) begin
      n = $urandom_range(28, 36);
      repeat (n) begin
        text.push_back(CH_OPEN);
        if ($urandom_range(0, 1) == 1) begin
          text.push_back(rand_digit());
          text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        end
      end
      text.push_back(rand_digit());
      repeat ($urandom_range(n - 3, n + 1)) text.push_back(CH_CLOSE);
      text.push_back(rand_digit());
    end else begin
      repeat ($urandom_range(1, 8)) begin
        r = $urandom_range(0, 9);
        case (r)
          0, 1, 2, 3: begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
            repeat (n) text.push_back(rand_digit());
          end
          4, 5: text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
          6: begin
            text.push_back(CH_OPEN);
            opens++;
          end
          7: begin
            if (opens > 0) begin
              text.push_back(CH_CLOSE);
              opens--;
            end else if (kind < 4) begin
              text.push_back(CH_CLOSE);
            end else begin
              text.push_back(CH_PLUS);
            end
          end
          8: text.push_back(8'($urandom_range(0, 255)));
          default: begin
            text.push_back(CH_MINUS);
            text.push_back(CH_OPEN);
            opens++;
          end
        endcase
      end
      if (kind >= 3) begin
        repeat (opens) text.push_back(CH_CLOSE);
      end
    end
  endtask

  task automatic send_expr();
    logic [7:0] text [$];
    build_expr(text);
    foreach (text[i]) begin
      send_char(text[i], i == text.size() - 1, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    total_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (totals_due.size() == 0) begin
        report_mismatch("unexpected result value", out_value, 32'd0);
      end else begin
        want = totals_due.pop_front();
        if (out_value !== want.value) begin
          report_mismatch("value", out_value, want.value);
        end
        if (out_status !== want.status) begin
          report_mismatch("status", 32'(out_status), 32'(want.status));
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    feed_gaps = 1'b1;
    sink_gaps <= 1'b1;
    foreach (plan[i]) begin
      send_char(plan[i].ch, plan[i].last, plan[i].typed,
                '{value: plan[i].value, status: plan[i].status});
    end
    while (chars_sent < 440 || exprs_done < 50) begin
      feed_gaps = ($urandom_range(0, 3) != 0);
      sink_gaps <= ($urandom_range(0, 3) != 0);
      send_expr();
    end
    feed_gaps = 1'b0;
    sink_gaps <= 1'b0;
    while (chars_sent < 500) send_expr();
    in_valid <= 1'b0;
    while (totals_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
